[src/tld_pkg.sv]
// shared types and constants for the tty line discipline
package tld_pkg;

    localparam int LEN_W    = 12;
    localparam int MAX_LINE = 4095;
    localparam int MAX_RES  = 4;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam logic [1:0] KIND_ECHO   = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_ERASE  = 2'd2;

    localparam logic [2:0] REG_IGNORE_CR  = 3'd0;
    localparam logic [2:0] REG_CR_TO_NL   = 3'd1;
    localparam logic [2:0] REG_NL_TO_CR   = 3'd2;
    localparam logic [2:0] REG_CANONICAL  = 3'd3;
    localparam logic [2:0] REG_ECHO_ON    = 3'd4;
    localparam logic [2:0] REG_ECHO_ERASE = 3'd5;
    localparam logic [2:0] REG_MIN_CHARS  = 3'd6;
    localparam logic [2:0] REG_READ_LIMIT = 3'd7;

    typedef struct packed {
        logic             ignore_cr;
        logic             cr_to_nl;
        logic             nl_to_cr;
        logic             canonical;
        logic             echo_on;
        logic             echo_erase;
        logic [7:0]       min_chars;
        logic [LEN_W-1:0] read_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic             done;
        logic [LEN_W-1:0] len;
    } result_t;

    typedef struct packed {
        result_t [MAX_RES-1:0] ent;
        logic [2:0]            n;
    } burst_t;

endpackage

[src/tld_cfg_regs.sv]
// configuration register file of the line discipline
module tld_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_addr,
    input  logic [11:0]       cfg_wdata,
    output tld_pkg::cfg_t     cfg
);
    import tld_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ignore_cr  <= 1'b0;
            cfg_reg.cr_to_nl   <= 1'b1;
            cfg_reg.nl_to_cr   <= 1'b0;
            cfg_reg.canonical  <= 1'b1;
            cfg_reg.echo_on    <= 1'b1;
            cfg_reg.echo_erase <= 1'b1;
            cfg_reg.min_chars  <= 8'd1;
            cfg_reg.read_limit <= 12'd4095;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_IGNORE_CR:  cfg_reg.ignore_cr  <= cfg_wdata[0];
                REG_CR_TO_NL:   cfg_reg.cr_to_nl   <= cfg_wdata[0];
                REG_NL_TO_CR:   cfg_reg.nl_to_cr   <= cfg_wdata[0];
                REG_CANONICAL:  cfg_reg.canonical  <= cfg_wdata[0];
                REG_ECHO_ON:    cfg_reg.echo_on    <= cfg_wdata[0];
                REG_ECHO_ERASE: cfg_reg.echo_erase <= cfg_wdata[0];
                REG_MIN_CHARS:  cfg_reg.min_chars  <= cfg_wdata[7:0];
                REG_READ_LIMIT: cfg_reg.read_limit <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/tld_decode.sv]
// byte translation and edit logic, builds the result burst for one byte
module tld_decode (
    input  logic [7:0]              rx_byte,
    input  tld_pkg::cfg_t           cfg,
    input  logic [11:0]             count,
    output tld_pkg::burst_t         burst,
    output logic [11:0]             count_next
);
    import tld_pkg::*;

    logic             is_cr;
    logic             drop;
    logic [7:0]       ch;
    logic             bs_edit;
    logic [LEN_W-1:0] limit;
    logic [LEN_W-1:0] inc;
    logic             done;
    result_t          app;

    always_comb begin
        is_cr = (rx_byte == CH_CR);
        drop  = is_cr && cfg.ignore_cr;
        ch    = rx_byte;
        if (is_cr) begin
            if (cfg.cr_to_nl) begin
                ch = CH_NL;
            end
        end else if (rx_byte == CH_NL && cfg.nl_to_cr) begin
            ch = CH_CR;
        end else if (rx_byte == CH_DEL) begin
            ch = CH_BS;
        end
        bs_edit = (ch == CH_BS) && cfg.canonical;
    end

    // effective read limit: capped by the line size, zero taken as one
    always_comb begin
        if (int'(cfg.read_limit) > MAX_LINE) begin
            limit = LEN_W'(MAX_LINE);
        end else begin
            limit = cfg.read_limit;
        end
        if (limit == '0) begin
            limit = LEN_W'(1);
        end
        inc  = count + LEN_W'(1);
        done = (!cfg.canonical && inc >= {4'd0, cfg.min_chars})
            || (cfg.canonical && ch == CH_NL)
            || (inc >= limit);
        app  = '{KIND_APPEND, ch, done, inc};
    end

    always_comb begin
        burst      = '0;
        count_next = count;
        if (drop) begin
            burst.n = 3'd0;
        end else if (bs_edit) begin
            if (count != '0) begin
                count_next = count - LEN_W'(1);
                if (cfg.echo_erase) begin
                    burst.ent[0] = '{KIND_ECHO, CH_BS, 1'b0, count};
                    burst.ent[1] = '{KIND_ECHO, CH_SP, 1'b0, count};
                    burst.ent[2] = '{KIND_ECHO, CH_BS, 1'b0, count};
                    burst.ent[3] = '{KIND_ERASE, 8'd0, 1'b0, count_next};
                    burst.n      = 3'd4;
                end else if (cfg.echo_on) begin
                    burst.ent[0] = '{KIND_ECHO, CH_BS, 1'b0, count};
                    burst.ent[1] = '{KIND_ERASE, 8'd0, 1'b0, count_next};
                    burst.n      = 3'd2;
                end else begin
                    burst.ent[0] = '{KIND_ERASE, 8'd0, 1'b0, count_next};
                    burst.n      = 3'd1;
                end
            end else begin
                burst.ent[0] = '{KIND_ECHO, CH_BEL, 1'b0, count};
                burst.n      = 3'd1;
            end
        end else begin
            count_next = done ? '0 : inc;
            if (ch != CH_BS && cfg.echo_on) begin
                burst.ent[0] = '{KIND_ECHO, ch, 1'b0, count};
                burst.ent[1] = app;
                burst.n      = 3'd2;
            end else begin
                burst.ent[0] = app;
                burst.n      = 3'd1;
            end
        end
    end

endmodule

[src/tld_out_stage.sv]
// result register holding one burst, sends its items one per cycle while m_tready is high
module tld_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  tld_pkg::burst_t   burst_in,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // out_byte, read_done, line_length
    output logic [1:0]        m_tuser,   // kind
    output logic              m_tlast
);
    import tld_pkg::*;

    logic       burst_vld_reg;
    burst_t     burst_reg;
    logic [1:0] idx_reg;
    logic       last_now;
    logic       pop;
    result_t    cur;

    assign cur      = burst_reg.ent[idx_reg];
    assign last_now = ({1'b0, idx_reg} == (burst_reg.n - 3'd1));
    assign pop      = burst_vld_reg && m_tready && last_now;
    assign free     = !burst_vld_reg || pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_vld_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else if (load) begin
            burst_vld_reg <= (burst_in.n != 3'd0);
            idx_reg       <= 2'd0;
        end else if (burst_vld_reg && m_tready) begin
            if (last_now) begin
                burst_vld_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            burst_reg <= burst_in;
        end
    end

    assign m_tvalid = burst_vld_reg;
    assign m_tdata  = {3'd0, cur.len, cur.done, cur.data};
    assign m_tuser  = cur.kind;
    assign m_tlast  = last_now;

`ifndef ASSERT_OFF
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        burst_vld_reg |-> ({1'b0, idx_reg} < burst_reg.n))
        else $error("burst index past item count");
    a_burst_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("burst ended before its last item");
    a_done_on_append: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8]) |-> (m_tuser == KIND_APPEND))
        else $error("read done flagged on a non-append item");
`endif

endmodule

[src/tty_line_discipline_unit.sv]
// top level of the tty input line discipline
//
//  channel   direction  tdata                              tuser  tlast
//  s_        in         rx_byte [7:0]                      -      -
//  m_        out        out_byte, read_done, line_length   kind   last
//  cfg_      in         plain write: index 0..7, 12-bit data
//
//  an input byte gives zero to four items; one item leaves per cycle while
//  m_tready is high, set by the result register that sends its burst one
//  item at a time
//  input register and result register part the two sides: a new byte is taken
//  while a burst still waits on m_tready
//  reset is synchronous on aresetn low and clears the count and the valid flags
module tty_line_discipline_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_byte [7:0], read_done [8], line_length [20:9]
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [11:0] cfg_wdata
);
    import tld_pkg::*;

    cfg_t             cfg;
    burst_t           burst;
    logic             in_vld_reg;
    logic [7:0]       in_byte_reg;
    logic [LEN_W-1:0] count_reg;
    logic [LEN_W-1:0] count_next;
    logic             free;
    logic             load;

    tld_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tld_decode u_decode (
        .rx_byte    (in_byte_reg),
        .cfg        (cfg),
        .count      (count_reg),
        .burst      (burst),
        .count_next (count_next)
    );

    tld_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .burst_in (burst),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    assign load     = in_vld_reg && free;
    assign s_tready = !in_vld_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (load) begin
                in_vld_reg <= 1'b0;
            end
            if (load) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

`ifndef ASSERT_OFF
    a_held_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !load) |=> (in_vld_reg && $stable(in_byte_reg)))
        else $error("waiting input item lost or changed");
    a_count_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && burst.n != 3'd0 && burst.ent[burst.n[1:0] - 2'd1].done)
        |=> (count_reg == '0))
        else $error("count not restarted after completed read");
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_vld_reg |-> s_tready)
        else $error("input not ready while input register is empty");
`endif

endmodule
